>>> design/tkips_pkg.sv
// Shared types and constants for the top-k inner product search block.
// Depends on nothing; every other design file refers to it by scoped names.
package tkips_pkg;

    localparam int VECTOR_LENGTH_RESET = 128;
    localparam int RESULTS_WANTED_RESET = 10;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [0:0] {
        REG_VECTOR_LENGTH  = 1'b0,
        REG_RESULTS_WANTED = 1'b1
    } cfg_reg_t;

    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic signed [15:0] element_t;
    typedef logic signed [31:0] product_t;
    typedef logic signed [47:0] score_t;
    typedef logic [23:0] result_index_t;
    typedef logic [3:0] result_rank_t;

    typedef struct packed {
        logic     operation;
        element_t element_value;
        logic     last_in_set;
    } item_t;

    typedef struct packed {
        result_index_t result_index;
        result_rank_t  result_rank;
        score_t        result_score;
        logic          last_result;
    } result_t;

    // Status a ranking cell shows its successor.
    typedef struct packed {
        logic valid;
        logic ge;
    } cell_flags_t;

    // Control of a finished beat leaving the dot-product pipeline.
    typedef struct packed {
        logic valid;
        logic insert;
        logic last;
    } ev_ctrl_t;

endpackage

>>> design/tkips_dot.sv
// Dot-product front end: element position, query memory, multiplier, accumulator.
// Uses tkips_pkg; feeds row scores to the ranking cells in the top level.
module tkips_dot #(
    parameter int MAX_DIM    = 1024,
    parameter int INDEX_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_fire,
    input  tkips_pkg::item_t              item,
    input  logic [$clog2(MAX_DIM+1)-1:0]  eff_len,
    output tkips_pkg::ev_ctrl_t           ev_ctrl,
    output logic [INDEX_BITS-1:0]         ev_index,
    output tkips_pkg::score_t             ev_score
);

    localparam int LEN_BITS = $clog2(MAX_DIM + 1);
    localparam int POS_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    tkips_pkg::element_t query_mem [MAX_DIM];

    logic [POS_BITS-1:0]   pos_reg, pos_next, pos_eff;
    logic [LEN_BITS-1:0]   pos_inc;
    logic                  wrap;
    logic [INDEX_BITS:0]   row_reg, row_next;
    logic                  is_data, end0, ins0, last0;

    // stage 1: query read data and element
    logic                  v1_reg, end1_reg, ins1_reg, last1_reg;
    logic [INDEX_BITS-1:0] row1_reg;
    tkips_pkg::element_t   q1_reg, e1_reg;
    // stage 2: product
    logic                  v2_reg, end2_reg, ins2_reg, last2_reg;
    logic [INDEX_BITS-1:0] row2_reg;
    tkips_pkg::product_t   prod2_reg;
    // stage 3: accumulate
    tkips_pkg::score_t     acc_reg, sum;
    tkips_pkg::ev_ctrl_t   ev_ctrl_reg;
    logic [INDEX_BITS-1:0] ev_index_reg;
    tkips_pkg::score_t     ev_score_reg;

    always_comb begin
        pos_eff = (LEN_BITS'(pos_reg) >= eff_len) ? '0 : pos_reg;
        pos_inc = LEN_BITS'(pos_eff) + LEN_BITS'(1);
        wrap    = (pos_inc >= eff_len);
        is_data = item.operation;
        last0   = is_data && item.last_in_set;
        end0    = is_data && wrap;
        ins0    = end0 && !row_reg[INDEX_BITS];

        pos_next = pos_reg;
        row_next = row_reg;
        if (in_fire) begin
            pos_next = (wrap || last0) ? '0 : POS_BITS'(pos_inc);
            if (last0) begin
                row_next = '0;
            end else if (ins0) begin
                row_next = row_reg + (INDEX_BITS+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            row_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            row_reg <= row_next;
        end
    end

    // query memory: write on query beats, registered read for data beats
    always_ff @(posedge aclk) begin
        if (in_fire && !is_data) begin
            query_mem[pos_eff] <= item.element_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_reg <= query_mem[pos_eff];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_fire && is_data;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg    <= item.element_value;
            end1_reg  <= end0;
            ins1_reg  <= ins0;
            last1_reg <= last0;
            row1_reg  <= row_reg[INDEX_BITS-1:0];

            prod2_reg <= q1_reg * e1_reg;
            end2_reg  <= end1_reg;
            ins2_reg  <= ins1_reg;
            last2_reg <= last1_reg;
            row2_reg  <= row1_reg;
        end
    end

    assign sum = acc_reg + {{16{prod2_reg[31]}}, prod2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            ev_ctrl_reg <= '0;
        end else if (adv) begin
            ev_ctrl_reg.valid  <= v2_reg;
            ev_ctrl_reg.insert <= v2_reg && ins2_reg;
            ev_ctrl_reg.last   <= v2_reg && last2_reg;
            if (v2_reg) begin
                // drop the sum at a row end or at the end of the run
                acc_reg <= (end2_reg || last2_reg) ? '0 : sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ev_index_reg <= row2_reg;
            ev_score_reg <= sum;
        end
    end

    assign ev_ctrl  = ev_ctrl_reg;
    assign ev_index = ev_index_reg;
    assign ev_score = ev_score_reg;

endmodule

>>> design/tkips_cell.sv
// One ranking cell: holds one kept row and shifts toward its successor on insert.
// Uses tkips_pkg; instantiated in a chain by the top level.
module tkips_cell #(
    parameter int INDEX_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    insert,
    input  logic                    clear,
    input  logic                    in_range,
    input  logic [INDEX_BITS-1:0]   new_index,
    input  tkips_pkg::score_t       new_score,
    input  tkips_pkg::cell_flags_t  prev_flags,
    input  logic [INDEX_BITS-1:0]   prev_index,
    input  tkips_pkg::score_t       prev_score,
    output tkips_pkg::cell_flags_t  flags,
    output logic [INDEX_BITS-1:0]   index,
    output tkips_pkg::score_t       score,
    output logic                    snap_valid,
    output logic [INDEX_BITS-1:0]   snap_index,
    output tkips_pkg::score_t       snap_score
);

    logic                  valid_reg;
    logic [INDEX_BITS-1:0] index_reg;
    tkips_pkg::score_t     score_reg;
    logic                  valid_eff, ge;
    logic                  upd_valid;
    logic [INDEX_BITS-1:0] upd_index;
    tkips_pkg::score_t     upd_score;

    always_comb begin
        valid_eff = valid_reg && in_range;
        // equal scores stay ahead: the incoming row always has the higher number
        ge        = valid_eff && (score_reg >= new_score);

        upd_valid = valid_reg;
        upd_index = index_reg;
        upd_score = score_reg;
        if (insert) begin
            if (!in_range) begin
                upd_valid = 1'b0;
            end else if (!ge) begin
                if (prev_flags.ge) begin
                    upd_valid = 1'b1;
                    upd_index = new_index;
                    upd_score = new_score;
                end else begin
                    upd_valid = prev_flags.valid;
                    upd_index = prev_index;
                    upd_score = prev_score;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= upd_valid && !clear;
        end
    end

    always_ff @(posedge aclk) begin
        index_reg <= upd_index;
        score_reg <= upd_score;
    end

    assign flags.valid = valid_eff;
    assign flags.ge    = ge;
    assign index       = index_reg;
    assign score       = score_reg;
    assign snap_valid  = upd_valid && in_range;
    assign snap_index  = upd_index;
    assign snap_score  = upd_score;

endmodule

>>> design/top_k_inner_product_search.sv
// Top level of the top-k inner product search: config registers, ranking chain,
// result buffer. Uses tkips_pkg, tkips_dot and tkips_cell.
//
//   channel | ports                         | beat
//   --------+-------------------------------+-----------------------------------
//   input   | s_valid s_ready s_item        | one query or data element
//   result  | m_valid m_ready m_result      | one ranked row, best first
//   config  | cfg_valid cfg_ready cfg_index | one register write (cfg_data)
//
// One element is taken per cycle. A row's score passes the query/element, product and
// accumulate registers to the ranking chain; a run's list is copied into the result
// buffer as its end arrives, and drains one row per cycle while m_ready is high.
// The input stalls only when a run end arrives while the previous list is draining.
// Reset is synchronous and needs no clearing pass; query memory is unset until loaded.
module top_k_inner_product_search #(
    parameter int MAX_DIM    = 1024,
    parameter int TOP_K      = 10,
    parameter int INDEX_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tkips_pkg::item_t      s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tkips_pkg::result_t    m_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  tkips_pkg::cfg_reg_t   cfg_index,
    input  tkips_pkg::cfg_data_t  cfg_data
);

    localparam int LEN_BITS = $clog2(MAX_DIM + 1);
    localparam int KW       = $clog2(TOP_K + 1);

    function automatic logic [LEN_BITS-1:0] clamp_len(input tkips_pkg::cfg_data_t v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end else if (w > 32'(MAX_DIM)) begin
            w = 32'(MAX_DIM);
        end
        return LEN_BITS'(w);
    endfunction

    function automatic logic [KW-1:0] clamp_k(input logic [3:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end else if (w > 32'(TOP_K)) begin
            w = 32'(TOP_K);
        end
        return KW'(w);
    endfunction

    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [KW-1:0]         k_reg, k_next;

    logic                  adv, in_fire, out_fire, insert, emit;
    tkips_pkg::ev_ctrl_t   ev_ctrl;
    logic [INDEX_BITS-1:0] ev_index;
    tkips_pkg::score_t     ev_score;

    tkips_pkg::cell_flags_t cell_flags [TOP_K];
    logic [INDEX_BITS-1:0]  cell_index [TOP_K];
    tkips_pkg::score_t      cell_score [TOP_K];
    logic                   snap_valid [TOP_K];
    logic [INDEX_BITS-1:0]  snap_index [TOP_K];
    tkips_pkg::score_t      snap_score [TOP_K];

    logic                   ob_valid_reg [TOP_K];
    logic [INDEX_BITS-1:0]  ob_index_reg [TOP_K];
    tkips_pkg::score_t      ob_score_reg [TOP_K];
    logic                   ob_valid_sh  [TOP_K];
    logic [INDEX_BITS-1:0]  ob_index_sh  [TOP_K];
    tkips_pkg::score_t      ob_score_sh  [TOP_K];
    tkips_pkg::result_rank_t rank_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_comb begin
        len_next = len_reg;
        k_next   = k_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tkips_pkg::REG_VECTOR_LENGTH:  len_next = clamp_len(cfg_data);
                tkips_pkg::REG_RESULTS_WANTED: k_next   = clamp_k(cfg_data[3:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= clamp_len(tkips_pkg::cfg_data_t'(tkips_pkg::VECTOR_LENGTH_RESET));
            k_reg   <= clamp_k(4'(tkips_pkg::RESULTS_WANTED_RESET));
        end else begin
            len_reg <= len_next;
            k_reg   <= k_next;
        end
    end

    // hold the whole pipeline while a finished list waits for a busy buffer
    assign adv      = !(ev_ctrl.valid && ev_ctrl.last && ob_valid_reg[0]);
    assign s_ready  = adv;
    assign in_fire  = s_valid && adv;
    assign insert   = adv && ev_ctrl.insert;
    assign emit     = adv && ev_ctrl.last;
    assign out_fire = m_valid && m_ready;

    tkips_dot #(
        .MAX_DIM    (MAX_DIM),
        .INDEX_BITS (INDEX_BITS)
    ) u_dot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_fire  (in_fire),
        .item     (s_item),
        .eff_len  (len_reg),
        .ev_ctrl  (ev_ctrl),
        .ev_index (ev_index),
        .ev_score (ev_score)
    );

    for (genvar i = 0; i < TOP_K; i++) begin : g_cell
        tkips_pkg::cell_flags_t prev_flags;
        logic [INDEX_BITS-1:0]  prev_index;
        tkips_pkg::score_t      prev_score;

        if (i == 0) begin : g_head
            // the head sees an always-better predecessor
            assign prev_flags = '{valid: 1'b0, ge: 1'b1};
            assign prev_index = '0;
            assign prev_score = '0;
        end else begin : g_body
            assign prev_flags = cell_flags[i-1];
            assign prev_index = cell_index[i-1];
            assign prev_score = cell_score[i-1];
        end

        tkips_cell #(
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .insert     (insert),
            .clear      (emit),
            .in_range   (k_reg > KW'(i)),
            .new_index  (ev_index),
            .new_score  (ev_score),
            .prev_flags (prev_flags),
            .prev_index (prev_index),
            .prev_score (prev_score),
            .flags      (cell_flags[i]),
            .index      (cell_index[i]),
            .score      (cell_score[i]),
            .snap_valid (snap_valid[i]),
            .snap_index (snap_index[i]),
            .snap_score (snap_score[i])
        );

        if (i < TOP_K - 1) begin : g_sh
            assign ob_valid_sh[i] = ob_valid_reg[i+1];
            assign ob_index_sh[i] = ob_index_reg[i+1];
            assign ob_score_sh[i] = ob_score_reg[i+1];
        end else begin : g_sh_end
            assign ob_valid_sh[i] = 1'b0;
            assign ob_index_sh[i] = '0;
            assign ob_score_sh[i] = '0;
        end
    end

    // result buffer: load a whole list, then advance one row per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < TOP_K; j++) begin
                ob_valid_reg[j] <= 1'b0;
            end
            rank_reg <= '0;
        end else if (emit) begin
            for (int j = 0; j < TOP_K; j++) begin
                ob_valid_reg[j] <= snap_valid[j];
            end
            rank_reg <= '0;
        end else if (out_fire) begin
            for (int j = 0; j < TOP_K; j++) begin
                ob_valid_reg[j] <= ob_valid_sh[j];
            end
            rank_reg <= rank_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < TOP_K; j++) begin
            if (emit) begin
                ob_index_reg[j] <= snap_index[j];
                ob_score_reg[j] <= snap_score[j];
            end else if (out_fire) begin
                ob_index_reg[j] <= ob_index_sh[j];
                ob_score_reg[j] <= ob_score_sh[j];
            end
        end
    end

    assign m_valid               = ob_valid_reg[0];
    assign m_result.result_index = tkips_pkg::result_index_t'(ob_index_reg[0]);
    assign m_result.result_rank  = rank_reg;
    assign m_result.result_score = ob_score_reg[0];
    assign m_result.last_result  = !ob_valid_sh[0];

endmodule

>>> dv/tkips_ranking_check.sv
`timescale 1ns / 100ps
// Scoreboard for top_k_inner_product_search: follows the config and input beats,
// predicts each run's ranked rows and compares every result beat against them.
// Depends on tkips_pkg; also holds tkips_tb_pkg, the opcodes the stimulus shares.
package tkips_tb_pkg;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_DATA  = 1'b1;

endpackage

module tkips_ranking_check #(
    parameter int MAX_DIM    = 1024,
    parameter int TOP_K      = 10,
    parameter int INDEX_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  tkips_pkg::item_t      s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  tkips_pkg::result_t    m_result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  tkips_pkg::cfg_reg_t   cfg_index,
    input  tkips_pkg::cfg_data_t  cfg_data,
    output int unsigned           error_count,
    output int unsigned           rows_pending
);
    import tkips_pkg::*;
    import tkips_tb_pkg::*;

    localparam longint unsigned ROW_LIMIT = 64'd1 << INDEX_BITS;

    cfg_data_t       length_reg;
    logic [3:0]      wanted_reg;
    element_t        query_mem [MAX_DIM];
    int unsigned     position;
    score_t          dot_sum;
    longint unsigned row_num;
    score_t          kept_score [TOP_K];
    result_index_t   kept_row [TOP_K];
    int unsigned     kept_n;
    result_t         ranked_rows_due [$];

    function automatic int unsigned vector_span();
        if (length_reg == 0) return 1;
        if (length_reg > MAX_DIM) return MAX_DIM;
        return length_reg;
    endfunction

    function automatic int unsigned result_depth();
        if (wanted_reg == 0) return 1;
        if (wanted_reg > TOP_K) return TOP_K;
        return wanted_reg;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("ranking_check: %s mismatch at %0t: got %0d, expected %0d",
                 what, $time, got, want);
        error_count++;
    endtask

    // Insert a finished row; equal scores keep the earlier row ahead.
    task automatic rank_row(input result_index_t row, input score_t score);
        int unsigned k, at, i;
        k = result_depth();
        if (kept_n > k) kept_n = k;
        at = 0;
        while (at < kept_n && kept_score[at] >= score) at++;
        if (at >= k) return;
        i = (kept_n < k) ? kept_n : k - 1;
        while (i > at) begin
            kept_score[i] = kept_score[i - 1];
            kept_row[i] = kept_row[i - 1];
            i--;
        end
        kept_score[at] = score;
        kept_row[at] = row;
        if (kept_n < k) kept_n++;
    endtask

    task automatic take_element(input item_t beat);
        int unsigned len, at, k, n;
        element_t v;
        product_t prod;
        result_t row;
        len = vector_span();
        at = (position >= len) ? 0 : position;
        v = beat.element_value;
        if (beat.operation == OP_QUERY) begin
            query_mem[at] = v;
            at++;
            position = (at >= len) ? 0 : at;
            return;
        end
        prod = query_mem[at] * v;
        dot_sum = dot_sum + score_t'(prod);
        at++;
        if (at >= len) begin
            // rows past the index range are never kept
            if (row_num < ROW_LIMIT) begin
                rank_row(result_index_t'(row_num), dot_sum);
                row_num++;
            end
            dot_sum = '0;
            at = 0;
        end
        position = at;
        if (!beat.last_in_set) return;
        k = result_depth();
        n = (kept_n < k) ? kept_n : k;
        for (int i = 0; i < n; i++) begin
            row.result_index = kept_row[i];
            row.result_rank = result_rank_t'(i);
            row.result_score = kept_score[i];
            row.last_result = (i + 1 == n);
            ranked_rows_due.push_back(row);
        end
        position = 0;
        dot_sum = '0;
        row_num = 0;
        kept_n = 0;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            length_reg = cfg_data_t'(VECTOR_LENGTH_RESET);
            wanted_reg = 4'(RESULTS_WANTED_RESET);
            foreach (query_mem[i]) query_mem[i] = '0;
            position = 0;
            dot_sum = '0;
            row_num = 0;
            kept_n = 0;
            ranked_rows_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (ranked_rows_due.size() == 0) begin
                    flag_mismatch("unexpected result beat", m_result.result_index, 0);
                end else begin
                    want = ranked_rows_due.pop_front();
                    if (m_result.result_index != want.result_index)
                        flag_mismatch("result_index", m_result.result_index,
                                      want.result_index);
                    if (m_result.result_rank != want.result_rank)
                        flag_mismatch("result_rank", m_result.result_rank, want.result_rank);
                    if (m_result.result_score != want.result_score)
                        flag_mismatch("result_score", m_result.result_score,
                                      want.result_score);
                    if (m_result.last_result != want.last_result)
                        flag_mismatch("last_result", m_result.last_result, want.last_result);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VECTOR_LENGTH: begin
                        length_reg = cfg_data;
                    end
                    REG_RESULTS_WANTED: begin
                        wanted_reg = cfg_data[3:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) take_element(s_item);
        end
        rows_pending = ranked_rows_due.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Testbench top for top_k_inner_product_search: clock, reset, directed and random
// beats under several idle phases, and the verdict. Uses tkips_pkg and tkips_ranking_check.
module testbench;
    import tkips_pkg::*;
    import tkips_tb_pkg::*;

    localparam int MAX_DIM         = 1024;
    localparam int TOP_K           = 10;
    localparam int INDEX_BITS      = 24;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 80;
    localparam int SETTLE_CYCLES   = 24;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    item_t       s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    result_t     m_result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index = REG_VECTOR_LENGTH;
    cfg_data_t   cfg_data = '0;
    int unsigned error_count;
    int unsigned rows_pending;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_ask = 1'b0;
    int unsigned vec_len = VECTOR_LENGTH_RESET;
    int unsigned items_sent = 0;
    element_t    row_buf [MAX_DIM];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    top_k_inner_product_search #(
        .MAX_DIM(MAX_DIM), .TOP_K(TOP_K), .INDEX_BITS(INDEX_BITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tkips_ranking_check #(
        .MAX_DIM(MAX_DIM), .TOP_K(TOP_K), .INDEX_BITS(INDEX_BITS)
    ) ranking_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .rows_pending(rows_pending)
    );

    // Result side: random stalls, plus a long hold-off on each toggle of hold_ask.
    initial begin
        logic hold_seen;
        int unsigned hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic element_t random_value();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return -16'sd1;
            default: return element_t'($urandom);
        endcase
    endfunction

    task automatic send_element(input logic op, input element_t value, input logic last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_item <= '{op, value, last};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    // Write both registers back to back; the block must be idle.
    task automatic configure(input cfg_data_t len_word, input cfg_data_t k_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_VECTOR_LENGTH;
        cfg_data <= len_word;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= REG_RESULTS_WANTED;
        cfg_data <= k_word;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        vec_len = (len_word == 0) ? 1 : (len_word > MAX_DIM) ? MAX_DIM : len_word;
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(negedge aclk); while (rows_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_query();
        for (int e = 0; e < vec_len; e++)
            send_element(OP_QUERY, random_value(), $urandom_range(7) == 0);
    endtask

    // Mostly clean runs; some get stray query beats and an early end.
    task automatic random_run();
        int unsigned rows;
        logic broken, cut_short, again;
        element_t v;
        rows = $urandom_range(13);
        broken = ($urandom_range(4) == 0);
        cut_short = (rows == 0) || (broken && $urandom_range(1));
        for (int r = 0; r < rows; r++) begin
            // repeat the previous row now and then to force equal scores
            again = (r != 0) && ($urandom_range(3) == 0);
            for (int e = 0; e < vec_len; e++) begin
                if (broken && $urandom_range(15) == 0)
                    send_element(OP_QUERY, random_value(), 1'($urandom_range(1)));
                v = again ? row_buf[e] : random_value();
                row_buf[e] = v;
                send_element(OP_DATA, v, !cut_short && r == rows - 1 && e == vec_len - 1);
            end
        end
        if (cut_short) send_element(OP_DATA, random_value(), 1'b1);
    endtask

    task automatic random_phase(input int unsigned src, input int unsigned sink,
                                input int unsigned quota);
        int unsigned stop_at;
        cfg_data_t len_word;
        src_idle_pct = src;
        sink_stall_pct <= sink;
        len_word = ($urandom_range(5) == 0) ? cfg_data_t'($urandom_range(12, 7))
                                            : cfg_data_t'($urandom_range(6, 1));
        configure(len_word, cfg_data_t'($urandom));
        load_query();
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(7) == 0) load_query();
            random_run();
        end
        wait_quiet();
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        configure(11'd4, 11'd3);
        send_element(OP_QUERY, 16'sh7fff, 1'b0);
        send_element(OP_QUERY, 16'sh8000, 1'b0);
        send_element(OP_QUERY, 16'sd1, 1'b1);   // marked last on a query beat: no run end
        send_element(OP_QUERY, -16'sd1, 1'b0);
        repeat (4) send_element(OP_DATA, 16'sh8000, 1'b0);
        // two identical rows: the lower row number ranks first
        repeat (2) begin
            send_element(OP_DATA, 16'sh7fff, 1'b0);
            send_element(OP_DATA, 16'sh8000, 1'b0);
            send_element(OP_DATA, '0, 1'b0);
            send_element(OP_DATA, '0, 1'b0);
        end
        // a query beat inside a row takes a slot of the shared position
        send_element(OP_DATA, 16'sd5, 1'b0);
        send_element(OP_DATA, -16'sd7, 1'b0);
        send_element(OP_QUERY, 16'sh4000, 1'b0);
        send_element(OP_DATA, 16'sh7fff, 1'b1);
        // run ended inside its first row keeps nothing
        send_element(OP_DATA, 16'sh1234, 1'b1);
        repeat (3) send_element(OP_QUERY, random_value(), 1'b0);
        wait_quiet();

        // position 3 now lies past the shorter vector
        configure(11'd2, 11'd15);
        load_query();
        for (int r = 0; r < 3; r++)
            for (int e = 0; e < 2; e++)
                send_element(OP_DATA, random_value(), r == 2 && e == 1);
        wait_quiet();

        // zero length acts as one; then shrink the kept list in the middle of a run
        configure(11'd0, 11'd15);
        load_query();
        repeat (11) send_element(OP_DATA, random_value(), 1'b0);
        wait_quiet();
        configure(11'd0, 11'd0);
        send_element(OP_DATA, random_value(), 1'b1);
        wait_quiet();

        // length past the maximum: the run ends inside its first row
        configure(11'h7ff, 11'd10);
        repeat (4) send_element(OP_QUERY, 16'sh8000, 1'b0);
        repeat (3) send_element(OP_DATA, 16'sh8000, 1'b0);
        send_element(OP_DATA, 16'sh7fff, 1'b1);
        wait_quiet();

        // full-scale elements: largest positive and most negative sums
        configure(11'd8, 11'd10);
        for (int e = 0; e < 8; e++) send_element(OP_QUERY, 16'sh8000, 1'b0);
        for (int e = 0; e < 8; e++) send_element(OP_DATA, 16'sh8000, 1'b0);
        for (int e = 0; e < 8; e++)
            send_element(OP_DATA, 16'sh7fff, e == 7);
        wait_quiet();

        // hold off the result side so run ends back up and stall the input
        configure(11'd1, 11'd10);
        load_query();
        hold_ask <= ~hold_ask;
        repeat (3)
            for (int r = 0; r < 12; r++) send_element(OP_DATA, random_value(), r == 11);
        wait_quiet();

        random_phase(0, 0, RANDOM_ITEMS / 4);
        random_phase(86, 0, RANDOM_ITEMS / 4);
        random_phase(0, 86, RANDOM_ITEMS / 4);
        random_phase(7, 7, RANDOM_ITEMS / 4);

        if (error_count == 0 && rows_pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
design/tkips_pkg.sv
design/tkips_dot.sv
design/tkips_cell.sv
design/top_k_inner_product_search.sv
dv/tkips_ranking_check.sv
dv/testbench.sv
